// ----- hw/rtl/abps_pkg.sv -----
// Package for the alpha blending pixel store.
// Sizes, codes, state type and blend arithmetic; used by the top level.

package abps_pkg;

   localparam int MAX_SIDE       = 512;
   localparam int CHANNEL_BITS   = 8;
   localparam int CH_MAX         = (1 << CHANNEL_BITS) - 1;
   localparam int PIXEL_BITS     = 3 * CHANNEL_BITS;
   localparam int NUM_BITS       = 2 * CHANNEL_BITS;
   localparam int STORE_DEPTH    = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_BITS      = $clog2(STORE_DEPTH);
   localparam int SIZE_BITS      = 10;
   localparam int COORD_BITS     = 11;
   localparam int PROD_BITS      = 2 * SIZE_BITS;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = 10'd500;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_READ,
      ST_WAIT,
      ST_WRITE,
      ST_RESP
   } state_type;

   // s*a + d*(max-a), never above max*max
   function automatic logic [NUM_BITS-1:0] mix_num(input logic [CHANNEL_BITS-1:0] s,
                                                   input logic [CHANNEL_BITS-1:0] d,
                                                   input logic [CHANNEL_BITS-1:0] a);
      logic [CHANNEL_BITS-1:0] inv;
      logic [NUM_BITS:0]       sum;
      inv = CHANNEL_BITS'(CH_MAX) - a;
      sum = (NUM_BITS+1)'(NUM_BITS'(s) * NUM_BITS'(a))
          + (NUM_BITS+1)'(NUM_BITS'(d) * NUM_BITS'(inv));
      return sum[NUM_BITS-1:0];
   endfunction

   // floor(n / 255), exact for any n up to 255*255 (the mix_num range)
   function automatic logic [CHANNEL_BITS-1:0] div_max(input logic [NUM_BITS-1:0] n);
      logic [NUM_BITS:0] t;
      t = (NUM_BITS+1)'(n) + (NUM_BITS+1)'(1) + (NUM_BITS+1)'(n[NUM_BITS-1:CHANNEL_BITS]);
      return t[NUM_BITS-1:CHANNEL_BITS];
   endfunction

endpackage

// ----- hw/rtl/abps_ram.sv -----
// Generic single-port synchronous RAM with registered read.
// No dependencies.

module abps_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 262144
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/alpha_blend_pixel_store.sv -----
// Top level of the alpha blending pixel store: clipping, addressing, blend and result register.
// Depends on abps_pkg and abps_ram.
//
//   port group | direction | carries
//   req_*      | in        | item: opcode, pos_x, pos_y, src colour and alpha
//   rsp_*      | out       | item: read colour and alpha
//   csr_*      | in        | frame_width (index 0), frame_height (index 1)
//
// One item at a time. ST_CALC tests the clip and registers the address multiply; then a
// clipped write ends, a clipped read goes to ST_RESP, an opaque write to ST_WRITE, and a
// blended write or in-range read passes ST_READ and ST_WAIT for the RAM read, then ST_WRITE
// or ST_RESP. Synchronous reset clears control only; pixel RAM content is undefined until
// written. A read result waits in the output register while rsp_ready is low; the next
// item is still accepted, but a further read holds the input until the waiting item is taken.

module alpha_blend_pixel_store (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_opcode,
   input  logic signed [abps_pkg::COORD_BITS-1:0] req_pos_x,
   input  logic signed [abps_pkg::COORD_BITS-1:0] req_pos_y,
   input  logic [abps_pkg::CHANNEL_BITS-1:0]     req_src_red,
   input  logic [abps_pkg::CHANNEL_BITS-1:0]     req_src_green,
   input  logic [abps_pkg::CHANNEL_BITS-1:0]     req_src_blue,
   input  logic [abps_pkg::CHANNEL_BITS-1:0]     req_src_alpha,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [abps_pkg::CHANNEL_BITS-1:0]     rsp_out_red,
   output logic [abps_pkg::CHANNEL_BITS-1:0]     rsp_out_green,
   output logic [abps_pkg::CHANNEL_BITS-1:0]     rsp_out_blue,
   output logic [abps_pkg::CHANNEL_BITS-1:0]     rsp_out_alpha,
   input  logic                                  csr_wr_en,
   input  logic [abps_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [abps_pkg::SIZE_BITS-1:0]        csr_data
);

   localparam int CB = abps_pkg::CHANNEL_BITS;
   localparam int PB = abps_pkg::PIXEL_BITS;
   localparam int NB = abps_pkg::NUM_BITS;
   localparam int SB = abps_pkg::SIZE_BITS;
   localparam int AB = abps_pkg::ADDR_BITS;
   localparam int XB = abps_pkg::COORD_BITS;
   localparam int MB = abps_pkg::PROD_BITS;

   abps_pkg::state_type state_ff, state_in;

   logic [SB-1:0] frame_width_ff, frame_width_in;
   logic [SB-1:0] frame_height_ff, frame_height_in;

   logic          op_ff, op_in;
   logic [XB-1:0] x_ff, x_in;
   logic [XB-1:0] y_ff, y_in;
   logic [PB-1:0] src_ff, src_in;
   logic [CB-1:0] alpha_ff, alpha_in;
   logic          inside_ff, inside_in;
   logic [AB-1:0] addr_ff, addr_in;
   logic [PB-1:0] pix_ff, pix_in;
   logic [NB-1:0] num_ff [3];
   logic [NB-1:0] num_in [3];

   logic          rsp_valid_ff, rsp_valid_in;
   logic [PB-1:0] rsp_pix_ff, rsp_pix_in;
   logic [CB-1:0] rsp_alpha_ff, rsp_alpha_in;

   logic [SB-1:0] w_eff, h_eff;
   logic [MB-1:0] row_base;
   logic [MB:0]   lin_addr;
   logic          inside_now;
   logic          blend;
   logic          accept;
   logic          rsp_load;
   logic [PB-1:0] mixed;

   logic          ram_en, ram_we;
   logic [PB-1:0] ram_wdata, ram_rdata;

   // sizes above the store side saturate
   assign w_eff = (32'(frame_width_ff) > abps_pkg::MAX_SIDE) ?
                  SB'(abps_pkg::MAX_SIDE) : frame_width_ff;
   assign h_eff = (32'(frame_height_ff) > abps_pkg::MAX_SIDE) ?
                  SB'(abps_pkg::MAX_SIDE) : frame_height_ff;

   assign inside_now = !x_ff[XB-1] && !y_ff[XB-1]
                     && (x_ff[SB-1:0] < w_eff) && (y_ff[SB-1:0] < h_eff);
   assign row_base = MB'(y_ff[SB-1:0]) * MB'(w_eff);
   assign lin_addr = (MB+1)'(row_base) + (MB+1)'(x_ff[SB-1:0]);

   assign blend    = (alpha_ff != CB'(abps_pkg::CH_MAX));
   assign accept   = req_valid && req_ready;
   assign rsp_load = (state_ff == abps_pkg::ST_RESP) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mixed[c*CB +: CB] = blend ? abps_pkg::div_max(num_ff[c]) : src_ff[c*CB +: CB];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         abps_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = abps_pkg::ST_CALC;
            end
         end
         abps_pkg::ST_CALC: begin
            if (!inside_now) begin
               state_in = (op_ff == abps_pkg::OP_READ) ? abps_pkg::ST_RESP : abps_pkg::ST_IDLE;
            end else if (op_ff == abps_pkg::OP_WRITE && !blend) begin
               state_in = abps_pkg::ST_WRITE;
            end else begin
               state_in = abps_pkg::ST_READ;
            end
         end
         abps_pkg::ST_READ: begin
            state_in = abps_pkg::ST_WAIT;
         end
         abps_pkg::ST_WAIT: begin
            state_in = (op_ff == abps_pkg::OP_READ) ? abps_pkg::ST_RESP : abps_pkg::ST_WRITE;
         end
         abps_pkg::ST_WRITE: begin
            state_in = abps_pkg::ST_IDLE;
         end
         abps_pkg::ST_RESP: begin
            if (rsp_load) begin
               state_in = abps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = abps_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      ram_en    = 1'b0;
      ram_we    = 1'b0;
      ram_wdata = mixed;
      case (state_ff)
         abps_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         abps_pkg::ST_READ: begin
            ram_en = 1'b1;
         end
         abps_pkg::ST_WRITE: begin
            ram_en = 1'b1;
            ram_we = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            abps_pkg::CSR_FRAME_WIDTH:  frame_width_in  = csr_data;
            abps_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_data;
            default:                    frame_width_in  = frame_width_ff;
         endcase
      end
   end

   always_comb begin
      op_in     = op_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      src_in    = src_ff;
      alpha_in  = alpha_ff;
      inside_in = inside_ff;
      addr_in   = addr_ff;
      pix_in    = pix_ff;
      num_in    = num_ff;
      if (accept) begin
         op_in    = req_opcode;
         x_in     = req_pos_x;
         y_in     = req_pos_y;
         src_in   = {req_src_red, req_src_green, req_src_blue};
         alpha_in = req_src_alpha;
      end
      if (state_ff == abps_pkg::ST_CALC) begin
         inside_in = inside_now;
         addr_in   = AB'(lin_addr);
      end
      if (state_ff == abps_pkg::ST_WAIT) begin
         pix_in = ram_rdata;
         for (int c = 0; c < 3; c++) begin
            num_in[c] = abps_pkg::mix_num(src_ff[c*CB +: CB], ram_rdata[c*CB +: CB], alpha_ff);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pix_in   = rsp_pix_ff;
      rsp_alpha_in = rsp_alpha_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_pix_in   = inside_ff ? pix_ff : '0;
         rsp_alpha_in = inside_ff ? CB'(abps_pkg::CH_MAX) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= abps_pkg::ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         frame_width_ff  <= abps_pkg::SIZE_RESET;
         frame_height_ff <= abps_pkg::SIZE_RESET;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      src_ff       <= src_in;
      alpha_ff     <= alpha_in;
      inside_ff    <= inside_in;
      addr_ff      <= addr_in;
      pix_ff       <= pix_in;
      num_ff       <= num_in;
      rsp_pix_ff   <= rsp_pix_in;
      rsp_alpha_ff <= rsp_alpha_in;
   end

   abps_ram #(
      .WIDTH (PB),
      .DEPTH (abps_pkg::STORE_DEPTH)
   ) u_pixel_ram (
      .clock   (clock),
      .en      (ram_en),
      .we      (ram_we),
      .addr    (addr_ff),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_pix_ff[2*CB +: CB];
   assign rsp_out_green = rsp_pix_ff[CB +: CB];
   assign rsp_out_blue  = rsp_pix_ff[0 +: CB];
   assign rsp_out_alpha = rsp_alpha_ff;

endmodule
